/* rtl/spwm_pkg.sv */
// Shared constants, register indexes and the quarter-wave sine routine for the sine PWM block.
package spwm_pkg;

	localparam int TABLE_SIZE_DEF    = 256;
	localparam int PERIOD_COUNTS_DEF = 4096;

	localparam int SINE_W   = 16;
	localparam int FIELD_W  = 13;
	localparam int CFG_W    = 17;
	localparam int CFG_IDX_W = 2;
	localparam int MOD_W    = 17;
	localparam int STEP_W   = 8;

	localparam logic [CFG_IDX_W-1:0] CFG_ENABLE     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MOD_INDEX  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP = 2'd2;

	localparam logic [MOD_W-1:0]  MOD_INDEX_RESET  = 17'd52429;
	localparam logic [STEP_W-1:0] PHASE_STEP_RESET = 8'd1;

	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] HALF_Q30    = 64'd536870912;
	localparam logic [63:0] SINE_MAX    = 64'd32767;

	localparam int TAYLOR_TERMS = 12;
	localparam logic [63:0] TAYLOR_DIV [1:TAYLOR_TERMS] = '{
		64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
		64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
	};

	// Integer Taylor series of sin(x) for x in Q30 on [0, pi/2]; result in Q30.
	function automatic logic [63:0] quarter_sine_q30(input logic [63:0] x);
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] pos;
		logic [63:0] neg;
		x2   = (x * x) >> 30;
		term = x;
		pos  = x;
		neg  = 64'd0;
		for (int k = 1; k <= TAYLOR_TERMS; k++) begin
			term = ((term * x2) >> 30) / TAYLOR_DIV[k];
			if (k % 2 == 1) begin
				neg = neg + term;
			end else begin
				pos = pos + term;
			end
		end
		return (pos > neg) ? pos - neg : 64'd0;
	endfunction

endpackage

/* rtl/spwm_sine_rom.sv */
// Sine lookup table in signed Q1.15, built at elaboration, with a registered read port.
module spwm_sine_rom #(
	parameter int TableSize = spwm_pkg::TABLE_SIZE_DEF
) (
	input  logic                                  clk,
	input  logic                                  rd_en,
	input  logic [$clog2(TableSize)-1:0]          addr,
	output logic signed [spwm_pkg::SINE_W-1:0]    data
);
	import spwm_pkg::*;

	typedef logic signed [SINE_W-1:0] rom_t [TableSize];

	function automatic rom_t build_rom();
		rom_t        r;
		logic [31:0] q4;
		logic [31:0] quad;
		logic [31:0] rem;
		logic [63:0] x;
		logic [63:0] mag;
		for (int i = 0; i < TableSize; i++) begin
			q4   = 32'(4 * i);
			quad = q4 / TableSize;
			rem  = q4 % TableSize;
			if (quad[0]) begin
				rem = 32'(TableSize) - rem;
			end
			x   = (HALF_PI_Q30 * 64'(rem)) / TableSize;
			mag = (quarter_sine_q30(x) * SINE_MAX + HALF_Q30) >> 30;
			if (mag > SINE_MAX) begin
				mag = SINE_MAX;
			end
			r[i] = (quad >= 32'd2) ? -SINE_W'(mag) : SINE_W'(mag);
		end
		return r;
	endfunction

	localparam rom_t Rom = build_rom();

	always_ff @(posedge clk) begin
		if (rd_en) begin
			data <= Rom[addr];
		end
	end

endmodule

/* rtl/sine_pwm_duty_generator_unit.sv */
// Top level of the sine PWM duty generator: phase state, configuration and a three-stage pipeline.
// Requests pass through the table read, multiply and clamp/scale stages, in that order.
// Throughput: one request per cycle while out_ready does not stall the output stage.
// Reset clears the phase to zero, disables modulation, loads the index 52429 and a step of one,
// and empties the pipeline. No clearing pass is needed; the sine table is constant.
module sine_pwm_duty_generator_unit #(
	parameter int TableSize    = spwm_pkg::TABLE_SIZE_DEF,
	parameter int PeriodCounts = spwm_pkg::PERIOD_COUNTS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [spwm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [spwm_pkg::CFG_W-1:0]          cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                advance,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [spwm_pkg::FIELD_W-1:0]        bridge1_high,
	output logic [spwm_pkg::FIELD_W-1:0]        bridge1_low,
	output logic [spwm_pkg::FIELD_W-1:0]        bridge2_high,
	output logic [spwm_pkg::FIELD_W-1:0]        bridge2_low
);
	import spwm_pkg::*;

	localparam int PhW        = $clog2(TableSize);
	localparam int PerW       = $clog2(PeriodCounts + 1);
	localparam int HalfPeriod = PeriodCounts / 2;
	localparam int StepCodes  = 1 << STEP_W;

	typedef logic [PhW-1:0] step_tab_t [StepCodes];

	function automatic step_tab_t build_step_tab();
		step_tab_t t;
		for (int s = 0; s < StepCodes; s++) begin
			t[s] = PhW'(s % TableSize);
		end
		return t;
	endfunction

	localparam step_tab_t StepMod = build_step_tab();

	localparam logic signed [34:0] OneQ31 = 35'sd2147483648;
	localparam logic signed [34:0] OneQ32 = 35'sd4294967296;
	localparam logic signed [33:0] OneQ31P = 34'sd2147483648;

	logic                    enable_q;
	logic [MOD_W-1:0]        mod_index_q;
	logic [PhW-1:0]          step_mod_q;
	logic [PhW-1:0]          phase_q;
	logic [PhW:0]            phase_sum;
	logic [PhW-1:0]          phase_next;

	logic                    en1;
	logic                    en2;
	logic                    en3;
	logic                    accept;

	logic                    v_s1;
	logic                    ena_s1;
	logic signed [SINE_W-1:0] sine_s1;

	logic                    v_s2;
	logic                    ena_s2;
	logic signed [33:0]      p_s2;
	logic signed [MOD_W:0]   mod_signed;

	logic                    out_valid_q;
	logic signed [34:0]      a_sum;
	logic [32:0]             a_clamp;
	logic [31:0]             b_clamp;
	logic [32+PerW:0]        a_prod;
	logic [31+PerW:0]        b_prod;
	logic [PerW-1:0]         h1;
	logic [PerW-1:0]         h2;
	logic [PerW-1:0]         l1;
	logic [PerW-1:0]         l2;

	assign en3      = !out_valid_q || out_ready;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;
	assign accept   = in_valid && en1;
	assign out_valid = out_valid_q;

	assign phase_sum  = {1'b0, phase_q} + {1'b0, step_mod_q};
	assign phase_next = (32'(phase_sum) >= TableSize) ?
		PhW'(32'(phase_sum) - TableSize) : phase_sum[PhW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q    <= 1'b0;
			mod_index_q <= MOD_INDEX_RESET;
			step_mod_q  <= StepMod[PHASE_STEP_RESET];
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ENABLE:     enable_q    <= cfg_data[0];
				CFG_MOD_INDEX:  mod_index_q <= cfg_data[MOD_W-1:0];
				CFG_PHASE_STEP: step_mod_q  <= StepMod[cfg_data[STEP_W-1:0]];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (accept && advance) begin
			phase_q <= phase_next;
		end
	end

	spwm_sine_rom #(
		.TableSize(TableSize)
	) u_rom (
		.clk  (clk),
		.rd_en(accept),
		.addr (phase_q),
		.data (sine_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= in_valid;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
			if (en3) begin
				out_valid_q <= v_s2;
			end
		end
	end

	assign mod_signed = signed'({1'b0, mod_index_q});

	always_ff @(posedge clk) begin
		if (accept) begin
			ena_s1 <= enable_q;
		end
		if (en2 && v_s1) begin
			ena_s2 <= ena_s1;
			p_s2   <= 34'(sine_s1) * 34'(mod_signed);
		end
	end

	always_comb begin
		a_sum = 35'(p_s2) + OneQ31;
		if (a_sum < 35'sd0) begin
			a_clamp = '0;
		end else if (a_sum > OneQ32) begin
			a_clamp = 33'(OneQ32);
		end else begin
			a_clamp = a_sum[32:0];
		end
		if (p_s2 < 34'sd0) begin
			b_clamp = '0;
		end else if (p_s2 > OneQ31P) begin
			b_clamp = 32'(OneQ31P);
		end else begin
			b_clamp = p_s2[31:0];
		end
		a_prod = (33 + PerW)'(a_clamp) * (33 + PerW)'(PeriodCounts);
		b_prod = (32 + PerW)'(b_clamp) * (32 + PerW)'(PeriodCounts);
		h1 = a_prod[32 +: PerW];
		h2 = b_prod[31 +: PerW];
		l1 = PerW'(PeriodCounts) - h1;
		l2 = PerW'(PeriodCounts) - h2;
	end

	always_ff @(posedge clk) begin
		if (en3 && v_s2) begin
			if (ena_s2) begin
				bridge1_high <= FIELD_W'(h1);
				bridge1_low  <= FIELD_W'(l1);
				bridge2_high <= FIELD_W'(h2);
				bridge2_low  <= FIELD_W'(l2);
			end else begin
				bridge1_high <= FIELD_W'(HalfPeriod);
				bridge1_low  <= FIELD_W'(HalfPeriod);
				bridge2_high <= FIELD_W'(HalfPeriod);
				bridge2_low  <= FIELD_W'(HalfPeriod);
			end
		end
	end

	// The phase never leaves the table.
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(phase_q) < TableSize)
		else $error("phase index outside the sine table");

	// A request without advance leaves the phase where it was.
	a_phase_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !advance && !(cfg_we)) |=> $stable(phase_q))
		else $error("phase moved without advance");

	// Each leg pair of a delivered result adds up to the period, modulo the field width.
	a_bridge1_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && $past(ena_s2) && $past(en3) && $past(v_s2)) |->
		(FIELD_W'(bridge1_high + bridge1_low) == FIELD_W'(PeriodCounts)))
		else $error("bridge 1 legs do not add up to the period");

	a_bridge2_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && $past(ena_s2) && $past(en3) && $past(v_s2)) |->
		(FIELD_W'(bridge2_high + bridge2_low) == FIELD_W'(PeriodCounts)))
		else $error("bridge 2 legs do not add up to the period");

	a_half_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(en3 && v_s2 && !ena_s2) |=>
		(bridge1_high == FIELD_W'(HalfPeriod) && bridge2_low == FIELD_W'(HalfPeriod)))
		else $error("disabled result not at half period");

endmodule

/* bench/tb_sine_pwm_duty_generator_unit.sv */
// Self-checking testbench for the sine PWM duty generator: predicts the four compare counts per request.
`timescale 1ns / 1ps

module tb_sine_pwm_duty_generator_unit;

	import spwm_pkg::*;

	localparam int TABLE_SIZE = TABLE_SIZE_DEF;
	localparam longint PERIOD = PERIOD_COUNTS_DEF;
	localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;
	localparam longint unsigned HALF_LSB_Q30 = 64'd536870912;
	localparam longint unsigned SAMPLE_MAX = 64'd32767;
	localparam longint ONE_Q31 = 64'sd2147483648;
	localparam longint ONE_Q32 = 64'sd4294967296;
	localparam int SETTLE_CYCLES = 4;

	typedef struct packed {
		logic [FIELD_W-1:0] bridge1_high;
		logic [FIELD_W-1:0] bridge1_low;
		logic [FIELD_W-1:0] bridge2_high;
		logic [FIELD_W-1:0] bridge2_low;
	} duty_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic advance;
	logic out_valid;
	logic out_ready;
	logic [FIELD_W-1:0] bridge1_high;
	logic [FIELD_W-1:0] bridge1_low;
	logic [FIELD_W-1:0] bridge2_high;
	logic [FIELD_W-1:0] bridge2_low;

	int sine_tab [TABLE_SIZE];
	logic enable_q;
	logic [MOD_W-1:0] mod_index_q;
	logic [STEP_W-1:0] step_q;
	logic [STEP_W-1:0] phase_q;

	duty_t pending_duties [$];
	int requests_sent;
	int results_seen;
	int mismatches;
	bit calm;

	sine_pwm_duty_generator_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.advance      (advance),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.bridge1_high (bridge1_high),
		.bridge1_low  (bridge1_low),
		.bridge2_high (bridge2_high),
		.bridge2_low  (bridge2_low)
	);

	always #10 clk = ~clk;

	function automatic longint unsigned taylor_sine(longint unsigned x);
		longint unsigned x2;
		longint unsigned term;
		longint unsigned pos;
		longint unsigned neg;
		int k;
		x2 = (x * x) >> 30;
		term = x;
		pos = x;
		neg = 0;
		for (k = 1; k <= 12; k++) begin
			term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
			if (k % 2 == 1) begin
				neg = neg + term;
			end else begin
				pos = pos + term;
			end
		end
		return (pos > neg) ? pos - neg : 64'd0;
	endfunction

	function automatic int sine_sample(int i);
		longint unsigned rem;
		longint unsigned x;
		longint unsigned mag;
		int quad;
		quad = (4 * i) / TABLE_SIZE;
		rem = (4 * i) % TABLE_SIZE;
		if (quad % 2 == 1) begin
			rem = TABLE_SIZE - rem;
		end
		x = (QUARTER_TURN_Q30 * rem) / TABLE_SIZE;
		mag = (taylor_sine(x) * SAMPLE_MAX + HALF_LSB_Q30) >> 30;
		if (mag > SAMPLE_MAX) begin
			mag = SAMPLE_MAX;
		end
		return (quad >= 2) ? -int'(mag) : int'(mag);
	endfunction

	function automatic duty_t compute_duties();
		duty_t d;
		longint prod;
		longint upper;
		longint lower;
		longint h1;
		longint h2;
		if (!enable_q) begin
			d.bridge1_high = FIELD_W'(PERIOD / 2);
			d.bridge1_low = FIELD_W'(PERIOD / 2);
			d.bridge2_high = FIELD_W'(PERIOD / 2);
			d.bridge2_low = FIELD_W'(PERIOD / 2);
		end else begin
			prod = longint'(sine_tab[phase_q]) * longint'(mod_index_q);
			upper = prod + ONE_Q31;
			lower = prod;
			if (upper < 0) begin
				upper = 0;
			end
			if (upper > ONE_Q32) begin
				upper = ONE_Q32;
			end
			if (lower < 0) begin
				lower = 0;
			end
			if (lower > ONE_Q31) begin
				lower = ONE_Q31;
			end
			h1 = (upper * PERIOD) >> 32;
			h2 = (lower * PERIOD) >> 31;
			d.bridge1_high = FIELD_W'(h1);
			d.bridge1_low = FIELD_W'(PERIOD - h1);
			d.bridge2_high = FIELD_W'(h2);
			d.bridge2_low = FIELD_W'(PERIOD - h2);
		end
		return d;
	endfunction

	function automatic int pick_gap();
		int r;
		if (calm) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end else if (r < 98) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	task automatic check_field(string name, logic [FIELD_W-1:0] want, logic [FIELD_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin : watch_ports
		duty_t got;
		duty_t want;
		if (out_valid && out_ready) begin
			results_seen++;
			got = '{bridge1_high, bridge1_low, bridge2_high, bridge2_low};
			if (pending_duties.size() == 0) begin
				$display("%0t: unexpected result, expected none actual %h", $time, got);
				mismatches++;
			end else begin
				want = pending_duties.pop_front();
				check_field("bridge1_high", want.bridge1_high, got.bridge1_high);
				check_field("bridge1_low", want.bridge1_low, got.bridge1_low);
				check_field("bridge2_high", want.bridge2_high, got.bridge2_high);
				check_field("bridge2_low", want.bridge2_low, got.bridge2_low);
			end
		end
		if (in_valid && in_ready) begin
			pending_duties.push_back(compute_duties());
			if (advance) begin
				phase_q = phase_q + step_q;
			end
		end
	end

	initial begin
		int gap;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			gap = pick_gap();
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	task automatic send_period(logic adv);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		advance <= adv;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		requests_sent++;
	endtask

	task automatic wait_for_quiet();
		in_valid <= 1'b0;
		while (results_seen < requests_sent) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(logic en, logic [MOD_W-1:0] mi, logic [STEP_W-1:0] st);
		wait_for_quiet();
		write_reg(CFG_ENABLE, {CFG_W'($urandom_range(0, 65535)) << 1} | CFG_W'(en));
		write_reg(CFG_MOD_INDEX, mi);
		write_reg(CFG_PHASE_STEP, {CFG_W'($urandom_range(0, 511)) << STEP_W} | CFG_W'(st));
		enable_q = en;
		mod_index_q = mi;
		step_q = st;
	endtask

	task automatic test_disabled();
		send_period(1'b1);
		send_period(1'b0);
		send_period(1'b1);
		send_period(1'b1);
	endtask

	task automatic test_extremes();
		int i;
		configure(1'b1, 17'd65536, STEP_W'(-phase_q));
		send_period(1'b1);
		configure(1'b1, 17'd65536, 8'd64);
		for (i = 0; i < 4; i++) begin
			send_period(1'b1);
		end
		configure(1'b1, 17'h1FFFF, 8'd64);
		for (i = 0; i < 4; i++) begin
			send_period(1'b1);
		end
		configure(1'b1, 17'd0, 8'd64);
		send_period(1'b1);
		send_period(1'b0);
		configure(1'b1, 17'd65536, 8'd255);
		for (i = 0; i < 3; i++) begin
			send_period(1'b1);
		end
		configure(1'b0, 17'd65536, 8'd255);
		send_period(1'b1);
	endtask

	task automatic test_random();
		int ph;
		int n;
		logic en;
		logic [MOD_W-1:0] mi;
		logic [STEP_W-1:0] st;
		for (ph = 0; ph < 16; ph++) begin
			en = (ph % 5 != 4);
			case ($urandom_range(0, 5))
				0: begin
					mi = 17'd0;
				end
				1: begin
					mi = 17'd65536;
				end
				2: begin
					mi = 17'h1FFFF;
				end
				3: begin
					mi = MOD_INDEX_RESET;
				end
				4: begin
					mi = MOD_W'($urandom_range(65537, 131071));
				end
				default: begin
					mi = MOD_W'($urandom_range(0, 65536));
				end
			endcase
			case ($urandom_range(0, 4))
				0: begin
					st = 8'd0;
				end
				1: begin
					st = 8'd1;
				end
				2: begin
					st = 8'd255;
				end
				default: begin
					st = STEP_W'($urandom_range(0, 255));
				end
			endcase
			configure(en, mi, st);
			calm = (ph % 4 == 3);
			for (n = 0; n < 95; n++) begin
				send_period(($urandom_range(0, 3) != 0));
			end
			calm = 1'b0;
		end
	endtask

	initial begin
		int i;
		for (i = 0; i < TABLE_SIZE; i++) begin
			sine_tab[i] = sine_sample(i);
		end
		enable_q = 1'b0;
		mod_index_q = MOD_INDEX_RESET;
		step_q = PHASE_STEP_RESET;
		phase_q = '0;
		requests_sent = 0;
		results_seen = 0;
		mismatches = 0;
		calm = 1'b0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_ENABLE;
		cfg_data <= '0;
		in_valid <= 1'b0;
		advance <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_disabled();
		test_extremes();
		test_random();
		wait_for_quiet();
		if (mismatches == 0 && pending_duties.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	initial begin
		#25_000_000;
		$display("FAIL");
		$finish;
	end

endmodule
